FILE: hw/rtl/tmg_pkg.sv
// shared types and constants of the touch to mouse gesture unit
`default_nettype none

package tmg_pkg;

    // field widths
    localparam int COUNT_W = 3;
    localparam int NX_W    = 10;
    localparam int NY_W    = 11;
    localparam int TIME_W  = 32;
    localparam int DX_W    = 12;
    localparam int DY_W    = 11;
    localparam int BTN_W   = 2;
    localparam int MS_W    = 16;
    localparam int PX_W    = 11;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 1;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_HOLD_LIM = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_MOVE_LIM = 1'b1;

    // configuration reset values
    localparam logic [MS_W-1:0] HOLD_LIM_RST = 16'd300;
    localparam logic [PX_W-1:0] MOVE_LIM_RST = 11'd10;

    // result kinds
    localparam logic KIND_MOTION = 1'b0;
    localparam logic KIND_BUTTON = 1'b1;

    // button masks
    localparam logic [BTN_W-1:0] BTN_NONE  = 2'd0;
    localparam logic [BTN_W-1:0] BTN_LEFT  = 2'd1;
    localparam logic [BTN_W-1:0] BTN_RIGHT = 2'd2;

    // number of results one poll produces
    localparam logic [1:0] NRES_NONE = 2'd0;
    localparam logic [1:0] NRES_ONE  = 2'd1;
    localparam logic [1:0] NRES_TWO  = 2'd2;

    typedef struct packed {
        logic [MS_W-1:0] hold_ms_lim;
        logic [PX_W-1:0] move_px_lim;
    } t_cfg;

    typedef struct packed {
        logic                   kind;
        logic signed [DX_W-1:0] delta_x;
        logic signed [DY_W-1:0] delta_y;
        logic [BTN_W-1:0]       buttons;
        logic                   last;
    } t_result;

    typedef struct packed {
        logic [1:0] n;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

`default_nettype wire

FILE: hw/rtl/tmg_in_if.sv
// poll channel: valid, ready and one touch poll
`default_nettype none

interface tmg_in_if;
    logic                          valid;
    logic                          ready;
    logic [tmg_pkg::COUNT_W-1:0]   point_count;
    logic [tmg_pkg::NX_W-1:0]      native_x;
    logic [tmg_pkg::NY_W-1:0]      native_y;
    logic [tmg_pkg::TIME_W-1:0]    now_ms;

    modport source (output valid, point_count, native_x, native_y, now_ms, input ready);
    modport sink   (input valid, point_count, native_x, native_y, now_ms, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/tmg_out_if.sv
// result channel: valid, ready and one mouse report
`default_nettype none

interface tmg_out_if;
    logic                               valid;
    logic                               ready;
    logic                               kind;
    logic signed [tmg_pkg::DX_W-1:0]    delta_x;
    logic signed [tmg_pkg::DY_W-1:0]    delta_y;
    logic [tmg_pkg::BTN_W-1:0]          buttons;
    logic                               last;

    modport source (output valid, kind, delta_x, delta_y, buttons, last, input ready);
    modport sink   (input valid, kind, delta_x, delta_y, buttons, last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/touch_to_mouse_gesture_unit.sv
// Touch to mouse gesture unit: turns touch controller polls into relative
// mouse motion and tap-to-click button reports.
// i_in carries one poll per transfer (contact count, portrait point, ms time);
// o_out carries one mouse report per transfer: motion (kind 0) or a button
// state update (kind 1); last marks the final report of a poll.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 tap time limit in ms, 1 tap movement limit in pixels); the user must
// write only while idle, as the block itself does not enforce this.
// Path: a poll is registered on transfer, then its reports are written into
// the result queue, whose head drives o_out.
// Throughput: one poll per cycle while the queue has room; a tap makes two
// reports, and the single output transfer per cycle then sets the pace.
// A poll leaves the input register only when the queue has room for two
// reports, so a stalled receiver fills the queue and then holds i_in.ready low.
// Reset clears the gesture state and the queue and restores the default
// limits (300 ms, 10 pixels).
`default_nettype none

module touch_to_mouse_gesture_unit #(
    parameter int OUT_DEPTH = 4
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    tmg_in_if.sink                              i_in,
    tmg_out_if.source                           o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [tmg_pkg::CIDX_W-1:0]     i_cfg_idx,
    input  wire logic [tmg_pkg::CFG_W-1:0]      i_cfg_data
);

    tmg_pkg::t_cfg   r_cfg;
    tmg_pkg::t_push  push;
    logic            room;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_ms_lim <= tmg_pkg::HOLD_LIM_RST;
            r_cfg.move_px_lim <= tmg_pkg::MOVE_LIM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tmg_pkg::CFG_HOLD_LIM: r_cfg.hold_ms_lim <= i_cfg_data;
                tmg_pkg::CFG_MOVE_LIM: r_cfg.move_px_lim <= i_cfg_data[tmg_pkg::PX_W-1:0];
                default: ;
            endcase
        end
    end

    tmg_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (r_cfg),
        .i_room  (room),
        .o_push  (push)
    );

    tmg_outq #(
        .DEPTH (OUT_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/tmg_core.sv
// poll register, gesture state and result formation
`default_nettype none

module tmg_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    tmg_in_if.sink              i_in,
    input  wire tmg_pkg::t_cfg  i_cfg,
    input  wire logic           i_room,
    output tmg_pkg::t_push      o_push
);

    // poll register
    logic                          r_in_valid;
    logic [tmg_pkg::COUNT_W-1:0]   r_count;
    logic [tmg_pkg::NX_W-1:0]      r_native_x;
    logic [tmg_pkg::NY_W-1:0]      r_native_y;
    logic [tmg_pkg::TIME_W-1:0]    r_now;

    // gesture state (landscape x is native y)
    logic                          r_touching;
    logic                          r_multi;
    logic [tmg_pkg::NY_W-1:0]      r_prev_x;
    logic [tmg_pkg::NX_W-1:0]      r_prev_y;
    logic [tmg_pkg::NY_W-1:0]      r_start_x;
    logic [tmg_pkg::NX_W-1:0]      r_start_y;
    logic [tmg_pkg::TIME_W-1:0]    r_start_time;

    logic                          n_touching;
    logic                          n_multi;

    logic                          advance;
    logic                          has_contact;
    logic                          many;
    logic [tmg_pkg::DX_W-1:0]      dx;
    logic [tmg_pkg::DY_W-1:0]      dy;
    logic [tmg_pkg::TIME_W-1:0]    dur;
    logic [tmg_pkg::NY_W-1:0]      mx;
    logic [tmg_pkg::NX_W-1:0]      my;
    logic                          tap;

    assign advance    = r_in_valid && i_room;
    assign i_in.ready = !r_in_valid || i_room;

    // capture a poll on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_count    <= i_in.point_count;
            r_native_x <= i_in.native_x;
            r_native_y <= i_in.native_y;
            r_now      <= i_in.now_ms;
        end
    end

    // motion and tap measurements
    assign has_contact = (r_count != '0);
    assign many        = (r_count >= tmg_pkg::COUNT_W'(2));
    assign dx  = {1'b0, r_native_y} - {1'b0, r_prev_x};
    assign dy  = {1'b0, r_native_x} - {1'b0, r_prev_y};
    assign dur = r_now - r_start_time;
    assign mx  = (r_prev_x >= r_start_x) ? (r_prev_x - r_start_x) : (r_start_x - r_prev_x);
    assign my  = (r_prev_y >= r_start_y) ? (r_prev_y - r_start_y) : (r_start_y - r_prev_y);
    assign tap = (dur < {16'd0, i_cfg.hold_ms_lim})
              && (mx < i_cfg.move_px_lim)
              && ({1'b0, my} < i_cfg.move_px_lim);

    // next gesture state
    always_comb begin
        n_touching = r_touching;
        n_multi    = r_multi;
        if (has_contact) begin
            n_touching = 1'b1;
            n_multi    = r_touching ? (r_multi || many) : many;
        end else if (r_touching) begin
            n_touching = 1'b0;
            n_multi    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touching   <= 1'b0;
            r_multi      <= 1'b0;
            r_prev_x     <= '0;
            r_prev_y     <= '0;
            r_start_x    <= '0;
            r_start_y    <= '0;
            r_start_time <= '0;
        end else if (advance) begin
            r_touching <= n_touching;
            r_multi    <= n_multi;
            if (has_contact) begin
                r_prev_x <= r_native_y;
                r_prev_y <= r_native_x;
                if (!r_touching) begin
                    r_start_x    <= r_native_y;
                    r_start_y    <= r_native_x;
                    r_start_time <= r_now;
                end
            end
        end
    end

    // results of this poll
    always_comb begin
        o_push.n          = tmg_pkg::NRES_NONE;
        o_push.r0.kind    = tmg_pkg::KIND_MOTION;
        o_push.r0.delta_x = dx;
        o_push.r0.delta_y = dy;
        o_push.r0.buttons = tmg_pkg::BTN_NONE;
        o_push.r0.last    = 1'b1;
        o_push.r1.kind    = tmg_pkg::KIND_BUTTON;
        o_push.r1.delta_x = '0;
        o_push.r1.delta_y = '0;
        o_push.r1.buttons = tmg_pkg::BTN_NONE;
        o_push.r1.last    = 1'b1;
        if (advance) begin
            if (has_contact) begin
                if (r_touching && ((dx != '0) || (dy != '0))) begin
                    o_push.n = tmg_pkg::NRES_ONE;
                end
            end else if (r_touching && tap) begin
                o_push.n          = tmg_pkg::NRES_TWO;
                o_push.r0.kind    = tmg_pkg::KIND_BUTTON;
                o_push.r0.delta_x = '0;
                o_push.r0.delta_y = '0;
                o_push.r0.buttons = r_multi ? tmg_pkg::BTN_RIGHT : tmg_pkg::BTN_LEFT;
                o_push.r0.last    = 1'b0;
            end
        end
    end

    // a tap always starts with a pressed button
    a_tap_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.n == tmg_pkg::NRES_TWO) |-> (o_push.r0.buttons != tmg_pkg::BTN_NONE))
        else $error("tap without button press");

    // results only come from a poll that moves on
    a_push_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.n != tmg_pkg::NRES_NONE) |-> advance)
        else $error("result without poll");

    // a release always leaves the multi-finger flag clear
    a_release_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !has_contact) |=> (!r_touching && !r_multi))
        else $error("state not cleared on release");

endmodule

`default_nettype wire

FILE: hw/rtl/tmg_outq.sv
// small result queue that takes up to two results per cycle
`default_nettype none

module tmg_outq #(
    parameter int DEPTH = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire tmg_pkg::t_push i_push,
    output logic                o_room,
    tmg_out_if.source           o_out
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    tmg_pkg::t_result  r_mem [DEPTH];
    logic [PW-1:0]     r_wr_ptr;
    logic [PW-1:0]     r_rd_ptr;
    logic [CW-1:0]     r_count;
    logic [PW-1:0]     n_wr_ptr;
    logic [PW-1:0]     wr_ptr1;
    logic [CW-1:0]     n_count;
    logic              pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign pop     = o_out.valid && o_out.ready;
    assign wr_ptr1 = ptr_inc(r_wr_ptr);
    assign o_room  = (r_count <= CW'(DEPTH - 2));

    // pointer and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        if (i_push.n == tmg_pkg::NRES_ONE) begin
            n_wr_ptr = wr_ptr1;
        end else if (i_push.n == tmg_pkg::NRES_TWO) begin
            n_wr_ptr = ptr_inc(wr_ptr1);
        end
        n_count = r_count + CW'(i_push.n) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
            if (pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push.n != tmg_pkg::NRES_NONE) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.n == tmg_pkg::NRES_TWO) begin
            r_mem[wr_ptr1] <= i_push.r1;
        end
    end

    // head of queue drives the result channel
    assign o_out.valid   = (r_count != '0);
    assign o_out.kind    = r_mem[r_rd_ptr].kind;
    assign o_out.delta_x = r_mem[r_rd_ptr].delta_x;
    assign o_out.delta_y = r_mem[r_rd_ptr].delta_y;
    assign o_out.buttons = r_mem[r_rd_ptr].buttons;
    assign o_out.last    = r_mem[r_rd_ptr].last;

    // never overfilled
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("result queue overflow");

    // pushes only arrive while there is room for two
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.n != tmg_pkg::NRES_NONE) |-> o_room)
        else $error("push without room");

    // count stays put with no push and no pop
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.n == tmg_pkg::NRES_NONE && !pop) |=> $stable(r_count))
        else $error("count moved while idle");

endmodule

`default_nettype wire

FILE: verif/touch_to_mouse_gesture_unit_test.sv
// self-checking testbench of the touch to mouse gesture unit
`timescale 1ns / 100ps

module touch_to_mouse_gesture_unit_test;

    localparam int RANDOM_POLLS = 1450;
    localparam int PHASES       = 8;
    localparam int DRAIN_CYCLES = 8;

    // field widths taken from the package
    localparam int COUNT_W = tmg_pkg::COUNT_W;
    localparam int NX_W    = tmg_pkg::NX_W;
    localparam int NY_W    = tmg_pkg::NY_W;
    localparam int TIME_W  = tmg_pkg::TIME_W;
    localparam int DX_W    = tmg_pkg::DX_W;
    localparam int DY_W    = tmg_pkg::DY_W;
    localparam int MS_W    = tmg_pkg::MS_W;
    localparam int PX_W    = tmg_pkg::PX_W;
    localparam int CFG_W   = tmg_pkg::CFG_W;
    localparam int CIDX_W  = tmg_pkg::CIDX_W;

    // one touch poll as the predictor sees it
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [NX_W-1:0]    nx;
        logic [NY_W-1:0]    ny;
        logic [TIME_W-1:0]  now;
    } t_poll;

    // gesture predictor and queue of predicted mouse reports
    class gesture_scoreboard;
        logic [MS_W-1:0]   tap_ms;
        logic [PX_W-1:0]   tap_px;
        logic              touching;
        logic              multi_seen;
        logic [NY_W-1:0]   prev_x;
        logic [NY_W-1:0]   start_x;
        logic [NX_W-1:0]   prev_y;
        logic [NX_W-1:0]   start_y;
        logic [TIME_W-1:0] start_time;
        tmg_pkg::t_result  reports_q[$];
        int                errors;
        int                motions;
        int                left_taps;
        int                right_taps;

        function new();
            tap_ms     = tmg_pkg::HOLD_LIM_RST;
            tap_px     = tmg_pkg::MOVE_LIM_RST;
            touching   = 1'b0;
            multi_seen = 1'b0;
            prev_x     = '0;
            start_x    = '0;
            prev_y     = '0;
            start_y    = '0;
            start_time = '0;
            errors     = 0;
            motions    = 0;
            left_taps  = 0;
            right_taps = 0;
        endfunction

        function void set_limit(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == tmg_pkg::CFG_HOLD_LIM) begin
                tap_ms = data;
            end else begin
                tap_px = data[PX_W-1:0];
            end
        endfunction

        // advance the gesture state by one accepted poll
        function void note_poll(t_poll p);
            logic [NY_W-1:0]   lx;
            logic [NX_W-1:0]   ly;
            logic [DX_W-1:0]   dx;
            logic [DY_W-1:0]   dy;
            logic [TIME_W-1:0] held;
            logic [NY_W-1:0]   mx;
            logic [NX_W-1:0]   my;
            tmg_pkg::t_result  r;
            // portrait to landscape
            lx = p.ny;
            ly = p.nx;
            if (p.count >= 2) begin
                multi_seen = 1'b1;
            end
            if (p.count != 0) begin
                if (touching) begin
                    dx = {1'b0, lx} - {1'b0, prev_x};
                    dy = {1'b0, ly} - {1'b0, prev_y};
                    if (dx != 0 || dy != 0) begin
                        r.kind    = tmg_pkg::KIND_MOTION;
                        r.delta_x = dx;
                        r.delta_y = dy;
                        r.buttons = tmg_pkg::BTN_NONE;
                        r.last    = 1'b1;
                        reports_q.push_back(r);
                        motions++;
                    end
                end else begin
                    start_time = p.now;
                    start_x    = lx;
                    start_y    = ly;
                    multi_seen = (p.count >= 2);
                end
                prev_x   = lx;
                prev_y   = ly;
                touching = 1'b1;
            end else if (touching) begin
                // release: tap if quick and nearly still on both axes
                held = p.now - start_time;
                mx   = (prev_x >= start_x) ? prev_x - start_x : start_x - prev_x;
                my   = (prev_y >= start_y) ? prev_y - start_y : start_y - prev_y;
                if (held < tap_ms && mx < tap_px && my < tap_px) begin
                    r.kind    = tmg_pkg::KIND_BUTTON;
                    r.delta_x = '0;
                    r.delta_y = '0;
                    r.buttons = multi_seen ? tmg_pkg::BTN_RIGHT : tmg_pkg::BTN_LEFT;
                    r.last    = 1'b0;
                    reports_q.push_back(r);
                    r.buttons = tmg_pkg::BTN_NONE;
                    r.last    = 1'b1;
                    reports_q.push_back(r);
                    if (multi_seen) begin
                        right_taps++;
                    end else begin
                        left_taps++;
                    end
                end
                touching   = 1'b0;
                multi_seen = 1'b0;
            end
        endfunction

        task report(string what);
            $display("MISMATCH at %0t ns: %s", $time, what);
            errors++;
        endtask

        // compare one transferred report with the oldest prediction
        task check_report(tmg_pkg::t_result got);
            tmg_pkg::t_result want;
            if (reports_q.size() == 0) begin
                report($sformatf("unexpected report kind %0d dx %0d dy %0d buttons %0d last %0d",
                                 got.kind, got.delta_x, got.delta_y, got.buttons, got.last));
                return;
            end
            want = reports_q.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("kind %0d, want %0d", got.kind, want.kind));
            if (got.delta_x !== want.delta_x)
                report($sformatf("delta_x %0d, want %0d", got.delta_x, want.delta_x));
            if (got.delta_y !== want.delta_y)
                report($sformatf("delta_y %0d, want %0d", got.delta_y, want.delta_y));
            if (got.buttons !== want.buttons)
                report($sformatf("buttons %0d, want %0d", got.buttons, want.buttons));
            if (got.last !== want.last)
                report($sformatf("last %0d, want %0d", got.last, want.last));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                i_cfg_we;
    logic [CIDX_W-1:0]   i_cfg_idx;
    logic [CFG_W-1:0]    i_cfg_data;

    tmg_in_if  poll_if ();
    tmg_out_if report_if ();

    gesture_scoreboard sb;
    logic [TIME_W-1:0] ms_now;
    logic              calm;
    int                stall_left;
    int                polls_sent;
    int                settings_used;
    tmg_pkg::t_result  seen_report;

    touch_to_mouse_gesture_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (poll_if),
        .o_out      (report_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // known values on every input from time zero
    initial begin
        sb                   = new();
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = tmg_pkg::CFG_HOLD_LIM;
        i_cfg_data           = '0;
        poll_if.valid        = 1'b0;
        poll_if.point_count  = '0;
        poll_if.native_x     = '0;
        poll_if.native_y     = '0;
        poll_if.now_ms       = '0;
        report_if.ready      = 1'b0;
        calm                 = 1'b0;
        stall_left           = 0;
        polls_sent           = 0;
        settings_used        = 1;
        ms_now               = '0;
    end

    // report monitor and receiver stalls
    always @(posedge i_clk) begin
        if (report_if.valid && report_if.ready) begin
            if (i_rst_n) begin
                seen_report.kind    = report_if.kind;
                seen_report.delta_x = report_if.delta_x;
                seen_report.delta_y = report_if.delta_y;
                seen_report.buttons = report_if.buttons;
                seen_report.last    = report_if.last;
                sb.check_report(seen_report);
            end
            stall_left = calm ? 0 : $urandom_range(0, 9);
            report_if.ready <= (stall_left == 0);
        end else if (!report_if.ready) begin
            if (stall_left <= 1) begin
                report_if.ready <= 1'b1;
            end
            if (stall_left > 0) begin
                stall_left--;
            end
        end
    end

    // one poll transfer after a random gap
    task automatic send_poll(input logic [COUNT_W-1:0] cnt, input logic [NX_W-1:0] nx,
                             input logic [NY_W-1:0] ny, input logic [TIME_W-1:0] now);
        int    gap;
        t_poll p;
        gap     = calm ? 0 : $urandom_range(0, 9);
        p.count = cnt;
        p.nx    = nx;
        p.ny    = ny;
        p.now   = now;
        if (gap > 0) begin
            poll_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        poll_if.valid       <= 1'b1;
        poll_if.point_count <= cnt;
        poll_if.native_x    <= nx;
        poll_if.native_y    <= ny;
        poll_if.now_ms      <= now;
        @(posedge i_clk);
        while (!poll_if.ready) @(posedge i_clk);
        sb.note_poll(p);
        polls_sent++;
    endtask

    // stop polling and let every predicted report drain
    task automatic settle();
        poll_if.valid <= 1'b0;
        while (sb.reports_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_limit(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int jitter(int base, int radius, int top);
        int v;
        v = base + int'($urandom_range(0, 2 * radius)) - radius;
        if (v < 0) v = 0;
        if (v > top) v = top;
        return v;
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        return ($urandom_range(0, 3) != 0) ? COUNT_W'(1) : COUNT_W'($urandom_range(1, 7));
    endfunction

    // one well-formed touch: start, a few moves, release
    task automatic run_gesture();
        int                moves;
        int                x0;
        int                y0;
        int                radius;
        int                lim_ms;
        int                lim_px;
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] stride;
        logic [TIME_W-1:0] t;
        lim_ms = sb.tap_ms;
        lim_px = sb.tap_px;
        moves  = $urandom_range(0, 6);
        x0     = $urandom_range(0, 719);
        y0     = $urandom_range(0, 1279);
        radius = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1279)
                                             : $urandom_range(0, lim_px + 1);
        span   = $urandom_range(0, lim_ms + lim_ms / 8 + 2);
        if ($urandom_range(0, 9) == 0) begin
            span = $urandom();
        end
        stride = span / (moves + 1);
        t      = ms_now;
        send_poll(pick_count(), NX_W'(x0), NY_W'(y0), t);
        for (int i = 0; i < moves; i++) begin
            t = t + stride;
            send_poll(pick_count(), NX_W'(jitter(x0, radius, 719)),
                      NY_W'(jitter(y0, radius, 1279)), t);
        end
        // the release point carries no meaning
        send_poll('0, NX_W'($urandom()), NY_W'($urandom()), ms_now + span);
        ms_now = ms_now + span + $urandom_range(1, 2000);
        if ($urandom_range(0, 29) == 0) begin
            ms_now = ($urandom_range(0, 1) == 0) ? $urandom() : 32'hFFFF_FFFF - $urandom_range(0, 400);
        end
    endtask

    // arbitrary polls over the full field widths
    task automatic run_noise();
        int bursts;
        bursts = $urandom_range(1, 4);
        for (int i = 0; i < bursts; i++) begin
            ms_now = ($urandom_range(0, 3) == 0) ? $urandom() : ms_now + $urandom_range(0, 500);
            send_poll(COUNT_W'($urandom_range(0, 7)), NX_W'($urandom()), NY_W'($urandom()),
                      ms_now);
        end
    endtask

    // main sequence
    initial begin
        logic [MS_W-1:0] ms_set[PHASES];
        logic [PX_W-1:0] px_set[PHASES];
        int              target;
        ms_set = '{16'd300, 16'd0, 16'd65535, 16'd1, 16'd0, 16'd65535, 16'd0, 16'd0};
        px_set = '{11'd10, 11'd0, 11'd1280, 11'd1, 11'd0, 11'd0, 11'd1280, 11'd0};
        ms_set[4] = $urandom_range(0, 65535);
        px_set[4] = $urandom_range(0, 1280);
        ms_set[7] = $urandom_range(20, 2000);
        px_set[7] = $urandom_range(2, 40);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed polls under the reset limits
        send_poll(3'd0, 10'd5, 11'd5, 32'd10);           // no contact while idle
        send_poll(3'd1, 10'd0, 11'd0, 32'd100);          // touch at the origin
        send_poll(3'd1, 10'd719, 11'd1279, 32'd110);     // largest positive motion
        send_poll(3'd1, 10'd0, 11'd0, 32'd120);          // largest negative motion
        send_poll(3'd1, 10'd0, 11'd0, 32'd130);          // no movement, no report
        send_poll(3'd0, 10'd0, 11'd0, 32'd150);          // quick release: left tap
        send_poll(3'd2, 10'd100, 11'd200, 32'd1000);     // two fingers at start
        send_poll(3'd5, 10'd102, 11'd203, 32'd1050);
        send_poll(3'd0, 10'd0, 11'd0, 32'd1100);         // right tap
        send_poll(3'd7, 10'd300, 11'd600, 32'd2000);     // count above five
        send_poll(3'd0, 10'd0, 11'd0, 32'd2300);         // held exactly the limit
        send_poll(3'd1, 10'd300, 11'd600, 32'hFFFF_FFF0);
        send_poll(3'd0, 10'd0, 11'd0, 32'h0000_0010);    // time wrap, still a tap
        send_poll(3'd1, 10'd1023, 11'd2047, 32'd5000);   // coordinates out of range
        send_poll(3'd1, 10'd0, 11'd0, 32'd5010);
        send_poll(3'd0, 10'd0, 11'd0, 32'd5020);
        send_poll(3'd1, 10'd50, 11'd50, 32'd6000);       // just under the pixel limit
        send_poll(3'd1, 10'd59, 11'd59, 32'd6010);
        send_poll(3'd0, 10'd0, 11'd0, 32'd6020);
        send_poll(3'd1, 10'd50, 11'd50, 32'd7000);       // at the pixel limit
        send_poll(3'd1, 10'd50, 11'd60, 32'd7010);
        send_poll(3'd0, 10'd0, 11'd0, 32'd7020);
        send_poll(3'd1, 10'd400, 11'd400, 32'd8000);     // second finger mid touch
        send_poll(3'd2, 10'd401, 11'd400, 32'd8010);
        send_poll(3'd1, 10'd400, 11'd400, 32'd8020);
        send_poll(3'd0, 10'd0, 11'd0, 32'd8299);
        ms_now = 32'd10000;

        // random phases, each under its own limits
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                settle();
                write_cfg(tmg_pkg::CFG_HOLD_LIM, CFG_W'(ms_set[ph]));
                write_cfg(tmg_pkg::CFG_MOVE_LIM, CFG_W'(px_set[ph]));
                settings_used++;
            end
            target = polls_sent + RANDOM_POLLS / PHASES;
            while (polls_sent < target) begin
                if ($urandom_range(0, 11) == 0) begin
                    calm = ~calm;
                end
                if ($urandom_range(0, 6) == 0) begin
                    run_noise();
                end else begin
                    run_gesture();
                end
            end
        end

        settle();
        $display("covered %0d polls under %0d limit settings", polls_sent, settings_used);
        $display("predicted %0d motion reports, %0d left taps, %0d right taps",
                 sb.motions, sb.left_taps, sb.right_taps);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("timeout with %0d reports still predicted", sb.reports_q.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/tmg_pkg.sv
hw/rtl/tmg_in_if.sv
hw/rtl/tmg_out_if.sv
hw/rtl/tmg_core.sv
hw/rtl/tmg_outq.sv
hw/rtl/touch_to_mouse_gesture_unit.sv
verif/touch_to_mouse_gesture_unit_test.sv
